// ----- src/spim_pkg.sv -----
package spim_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned TICKS_W     = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned BIT_CNT_W   = 3;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_POLARITY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PHASE    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_TICKS    = 2'd2;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic              req_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              frame_start;
    logic              frame_end;
    logic              miso;
  } in_item_t;

  typedef struct packed {
    logic              sclk;
    logic              mosi;
    logic              cs_n;
    logic              ready_res;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;
  } out_item_t;

  typedef struct packed {
    logic               clock_polarity;
    logic               clock_phase;
    logic [TICKS_W-1:0] phase_ticks;
  } cfg_t;

endpackage

// ----- src/spi_master_four_mode_shifter_core.sv -----
// a word's pin result passes through the input queue and then the sequencer's output
//   register before it shows on out_data
// throughput: one word per cycle while the result is not stalled; each word is one tick of the pin sequencer
// reset: synchronous, active low; sclk and mosi low, cs_n high, sequencer idle,
//   queue empty, mode 0 with phase_ticks of one
module spi_master_four_mode_shifter_core import spim_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // live configuration; the user must write it only while no word is in flight, which the block
  // does not enforce; the sequencer may be mid-transfer and picks up the new values at once
  logic               cpol_r;
  logic               cpha_r;
  logic [TICKS_W-1:0] ticks_r;
  cfg_t               cfg;

  // front to back handoff
  logic     q_valid;
  in_item_t q_item;
  logic     q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpol_r  <= 1'b0;
      cpha_r  <= 1'b0;
      ticks_r <= TICKS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_POLARITY: cpol_r  <= cfg_wdata[0];
        CFG_IDX_PHASE:    cpha_r  <= cfg_wdata[0];
        CFG_IDX_TICKS:    ticks_r <= cfg_wdata[TICKS_W-1:0];
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  assign cfg.clock_polarity = cpol_r;
  assign cfg.clock_phase    = cpha_r;
  assign cfg.phase_ticks    = ticks_r;

  // front: takes every tick word into a short queue
  spim_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // back: timed pin sequencer, one tick per popped word, registered result
  spim_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- src/spim_queue.sv -----
module spim_queue import spim_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  output in_item_t q_item,
  input  logic     q_pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  in_item_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign in_stall = (count_r == CNT_FULL);
  assign q_valid  = (count_r != '0);
  assign q_item   = mem[rd_ptr_r];

  assign push = in_valid && !in_stall;
  assign pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= in_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count beyond depth");
`endif

endmodule

// ----- src/spim_seq.sv -----
module spim_seq import spim_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  in_item_t  q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_A,
    ST_B,
    ST_C,
    ST_HOLD
  } seq_state_t;

  seq_state_t            state_r, state_nxt;
  logic [TICKS_W-1:0]    tick_r, tick_nxt;
  logic [BIT_CNT_W-1:0]  bit_r, bit_nxt;
  logic [BYTE_W-1:0]     tx_r, tx_nxt;
  logic [BYTE_W-1:0]     rx_r, rx_nxt;
  logic                  endp_r, endp_nxt;
  logic                  sclk_r, sclk_nxt;
  logic                  mosi_r, mosi_nxt;
  logic                  cs_r, cs_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;
  logic [TICKS_W-1:0]    span;
  logic                  step;

  assign span  = (cfg.phase_ticks == '0) ? TICKS_W'(1) : cfg.phase_ticks;
  assign step  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = step;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    logic is_first;
    logic is_last;
    logic rx_done;
    logic [BYTE_W-1:0] rx_got;

    state_nxt = state_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    tx_nxt    = tx_r;
    rx_nxt    = rx_r;
    endp_nxt  = endp_r;
    sclk_nxt  = sclk_r;
    mosi_nxt  = mosi_r;
    cs_nxt    = cs_r;
    rx_done   = 1'b0;
    rx_got    = '0;
    is_first  = 1'b0;
    is_last   = 1'b0;

    // idle tick: park the clock, maybe start a request
    if (state_r == ST_IDLE) begin
      sclk_nxt = cfg.clock_polarity;
      if (q_item.req_valid) begin
        tx_nxt    = q_item.tx_byte;
        rx_nxt    = '0;
        bit_nxt   = '0;
        endp_nxt  = q_item.frame_end;
        tick_nxt  = '0;
        state_nxt = q_item.frame_start ? ST_SETUP : ST_A;
      end
    end

    if (state_nxt != ST_IDLE) begin
      is_first = (tick_nxt == '0);
      is_last  = ({1'b0, tick_nxt} + 1'b1) >= {1'b0, span};
      unique case (state_nxt)
        ST_SETUP: begin
          if (is_first && bit_nxt == '0) begin
            cs_nxt = 1'b0;
          end
          if (is_last) begin
            tick_nxt = '0;
            if (bit_nxt == '0) begin
              bit_nxt = BIT_CNT_W'(1);
            end else begin
              bit_nxt   = '0;
              state_nxt = ST_A;
            end
          end else begin
            tick_nxt = tick_nxt + 1'b1;
          end
        end
        ST_A: begin
          if (is_first) begin
            if (!cfg.clock_phase) begin
              mosi_nxt = tx_nxt[BYTE_W-1];
              tx_nxt   = {tx_nxt[BYTE_W-2:0], 1'b0};
            end else begin
              sclk_nxt = !cfg.clock_polarity;
            end
          end
          if (is_last) begin
            tick_nxt  = '0;
            state_nxt = ST_B;
          end else begin
            tick_nxt = tick_nxt + 1'b1;
          end
        end
        ST_B: begin
          if (is_first) begin
            if (!cfg.clock_phase) begin
              sclk_nxt = !cfg.clock_polarity;
            end else begin
              mosi_nxt = tx_nxt[BYTE_W-1];
              tx_nxt   = {tx_nxt[BYTE_W-2:0], 1'b0};
            end
          end
          if (is_last) begin
            tick_nxt  = '0;
            state_nxt = ST_C;
          end else begin
            tick_nxt = tick_nxt + 1'b1;
          end
        end
        ST_C: begin
          if (is_first) begin
            sclk_nxt = cfg.clock_polarity;
          end
          // mode with phase 0 samples on entry, phase 1 on the last tick
          if ((is_first && !cfg.clock_phase) || (is_last && cfg.clock_phase)) begin
            rx_nxt = {rx_nxt[BYTE_W-2:0], q_item.miso};
            if (bit_nxt == LAST_BIT) begin
              rx_done = 1'b1;
              rx_got  = rx_nxt;
            end
          end
          if (is_last) begin
            tick_nxt = '0;
            if (bit_nxt == LAST_BIT) begin
              bit_nxt   = '0;
              state_nxt = endp_nxt ? ST_HOLD : ST_IDLE;
            end else begin
              bit_nxt   = bit_nxt + 1'b1;
              state_nxt = ST_A;
            end
          end else begin
            tick_nxt = tick_nxt + 1'b1;
          end
        end
        ST_HOLD: begin
          if (is_last) begin
            tick_nxt = '0;
            if (bit_nxt == '0) begin
              bit_nxt = BIT_CNT_W'(1);
            end else begin
              bit_nxt   = '0;
              cs_nxt    = 1'b1;
              endp_nxt  = 1'b0;
              state_nxt = ST_IDLE;
            end
          end else begin
            tick_nxt = tick_nxt + 1'b1;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
          tick_nxt  = '0;
          bit_nxt   = '0;
        end
      endcase
    end

    out_data_nxt.sclk      = sclk_nxt;
    out_data_nxt.mosi      = mosi_nxt;
    out_data_nxt.cs_n      = cs_nxt;
    out_data_nxt.ready_res = (state_r == ST_IDLE);
    out_data_nxt.rx_valid  = rx_done;
    out_data_nxt.rx_byte   = rx_got;

    out_valid_nxt = step || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      bit_r       <= '0;
      tx_r        <= '0;
      rx_r        <= '0;
      endp_r      <= 1'b0;
      sclk_r      <= 1'b0;
      mosi_r      <= 1'b0;
      cs_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        state_r    <= state_nxt;
        tick_r     <= tick_nxt;
        bit_r      <= bit_nxt;
        tx_r       <= tx_nxt;
        rx_r       <= rx_nxt;
        endp_r     <= endp_nxt;
        sclk_r     <= sclk_nxt;
        mosi_r     <= mosi_nxt;
        cs_r       <= cs_nxt;
        out_data_r <= out_data_nxt;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_rx_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.rx_valid |-> !out_data_r.ready_res)
    else $error("byte completed on an idle tick");

  a_cs_release: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(cs_r) |-> $past(state_r) == ST_HOLD)
    else $error("chip select released outside hold");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(state_r) && $stable(tick_r))
    else $error("sequencer advanced while result stalled");
`endif

endmodule

// ----- sim/spi_master_four_mode_shifter_core_test.sv -----
module spi_master_four_mode_shifter_core_test import spim_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // quiet cycles (nothing accepted on either side) before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // extra cycles waited after the last expected word has come back
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_WORDS_PER_PHASE = 470;

  // sequencer states of the pin predictor
  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_BIT_A, ST_BIT_B, ST_BIT_C, ST_HOLD
  } seq_state_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_IDX_POLARITY;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  spi_master_four_mode_shifter_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // words waiting for the driver, and pin levels expected back in order
  in_item_t  pending_words[$];
  out_item_t expected_pins[$];

  // idling odds in percent, changed only while the pipe is drained
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;

  // bookkeeping for the summary and the verdict
  int unsigned mismatches     = 0;
  int unsigned words_queued   = 0;
  int unsigned words_checked  = 0;
  int unsigned transfers_seen = 0;
  int unsigned bytes_received = 0;
  int unsigned reg_writes     = 0;
  logic [3:0]  modes_used     = '0;

  // shadow of the configuration registers
  logic               m_polarity = 1'b0;
  logic               m_phase    = 1'b0;
  logic [TICKS_W-1:0] m_ticks    = 16'd1;

  // predicted sequencer state, reset values
  seq_state_t         seq      = ST_IDLE;
  logic [TICKS_W-1:0] tick_cnt = '0;
  logic [2:0]         bit_cnt  = '0;
  logic [7:0]         tx_sh    = '0;
  logic [7:0]         rx_sh    = '0;
  logic               end_pend = 1'b0;
  logic               sclk_q   = 1'b0;
  logic               mosi_q   = 1'b0;
  logic               cs_q     = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one tick of the pin sequencer: advance the predicted state, return the pins
  function automatic out_item_t next_pins(in_item_t w);
    out_item_t  r;
    logic [16:0] span;
    logic       first_tick, last_tick, take;
    r = '0;
    span = (m_ticks == '0) ? 17'd1 : {1'b0, m_ticks};
    r.ready_res = (seq == ST_IDLE);
    if (seq == ST_IDLE) begin
      // idle clock level follows polarity even mid-run
      sclk_q = m_polarity;
      if (w.req_valid) begin
        tx_sh    = w.tx_byte;
        rx_sh    = '0;
        bit_cnt  = '0;
        end_pend = w.frame_end;
        tick_cnt = '0;
        seq      = w.frame_start ? ST_SETUP : ST_BIT_A;
        transfers_seen++;
        modes_used[{m_polarity, m_phase}] = 1'b1;
      end
    end
    // the accepting tick already performs the first action
    if (seq != ST_IDLE) begin
      first_tick = (tick_cnt == '0);
      last_tick  = ({1'b0, tick_cnt} + 17'd1 >= span);
      take       = 1'b0;
      case (seq)
        ST_SETUP, ST_HOLD: begin
          if (seq == ST_SETUP && first_tick && bit_cnt == '0) cs_q = 1'b0;
          // two delay units, bit_cnt tells them apart
          if (last_tick) begin
            if (bit_cnt == '0) begin
              bit_cnt = 3'd1;
            end else begin
              bit_cnt = '0;
              if (seq == ST_HOLD) begin
                cs_q     = 1'b1;
                end_pend = 1'b0;
                seq      = ST_IDLE;
              end else begin
                seq = ST_BIT_A;
              end
            end
          end
        end
        ST_BIT_A: begin
          if (first_tick) begin
            if (!m_phase) begin
              mosi_q = tx_sh[7];
              tx_sh  = tx_sh << 1;
            end else begin
              sclk_q = ~m_polarity;
            end
          end
          if (last_tick) seq = ST_BIT_B;
        end
        ST_BIT_B: begin
          if (first_tick) begin
            if (!m_phase) begin
              sclk_q = ~m_polarity;
            end else begin
              mosi_q = tx_sh[7];
              tx_sh  = tx_sh << 1;
            end
          end
          if (last_tick) seq = ST_BIT_C;
        end
        ST_BIT_C: begin
          if (first_tick) sclk_q = m_polarity;
          // phase 0 samples on the first tick of C, phase 1 on its last tick
          take = (first_tick && !m_phase) || (last_tick && m_phase);
          if (take) begin
            rx_sh = {rx_sh[6:0], w.miso};
            if (bit_cnt == LAST_BIT) begin
              r.rx_valid = 1'b1;
              r.rx_byte  = rx_sh;
            end
          end
          if (last_tick) begin
            if (bit_cnt == LAST_BIT) begin
              bit_cnt = '0;
              seq     = end_pend ? ST_HOLD : ST_IDLE;
            end else begin
              bit_cnt = bit_cnt + 3'd1;
              seq     = ST_BIT_A;
            end
          end
        end
        default: begin
          seq      = ST_IDLE;
          bit_cnt  = '0;
        end
      endcase
      tick_cnt = last_tick ? '0 : tick_cnt + 16'd1;
    end
    r.sclk = sclk_q;
    r.mosi = mosi_q;
    r.cs_n = cs_q;
    return r;
  endfunction

  function automatic void compare_pin(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  // driver: feeds queued words, predicts each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_pins.push_back(next_pins(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_data  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, field-by-field compare against oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pins.size() == 0) begin
          $error("result word with nothing expected: %h", out_data);
          mismatches++;
        end else begin
          want = expected_pins.pop_front();
          compare_pin("sclk", 8'(want.sclk), 8'(out_data.sclk));
          compare_pin("mosi", 8'(want.mosi), 8'(out_data.mosi));
          compare_pin("cs_n", 8'(want.cs_n), 8'(out_data.cs_n));
          compare_pin("ready_res", 8'(want.ready_res), 8'(out_data.ready_res));
          compare_pin("rx_valid", 8'(want.rx_valid), 8'(out_data.rx_valid));
          compare_pin("rx_byte", want.rx_byte, out_data.rx_byte);
          words_checked++;
          if (want.rx_valid) bytes_received++;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on stretches with no handshake at all
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_word(logic req, logic [7:0] tx, logic fs, logic fe, logic miso);
    in_item_t w;
    w.req_valid   = req;
    w.tx_byte     = tx;
    w.frame_start = fs;
    w.frame_end   = fe;
    w.miso        = miso;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // wait until every queued word is in and every result is back, then settle
  task automatic drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_pins.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // writes all three registers on consecutive edges; only called when drained
  task automatic set_mode(logic pol, logic ph, logic [TICKS_W-1:0] ticks);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_IDX_POLARITY; cfg_wdata <= {15'd0, pol};
    @(posedge clk);
    cfg_index <= CFG_IDX_PHASE; cfg_wdata <= {15'd0, ph};
    @(posedge clk);
    cfg_index <= CFG_IDX_TICKS; cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_polarity = pol;
    m_phase    = ph;
    m_ticks    = ticks;
    reg_writes += 3;
    @(negedge clk);
  endtask

  // one request timed to start from idle, followed by ignored requests while busy
  task automatic queue_transfer(logic [7:0] tx, logic fs, logic fe, logic miso);
    int unsigned span, ticks;
    span  = (m_ticks == '0) ? 1 : m_ticks;
    ticks = span * (24 + (fs ? 2 : 0) + (fe ? 2 : 0));
    push_word(1'b1, tx, fs, fe, miso);
    repeat (ticks - 1)
      push_word(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)),
                1'($urandom_range(1)), miso);
  endtask

  task automatic run_phase(int unsigned gap, int unsigned stall, int unsigned words);
    int unsigned sent, n, req_pct, pick;
    logic [TICKS_W-1:0] t;
    drain();
    send_gap_pct = gap;
    stall_pct    = stall;
    sent = 0;
    while (sent < words) begin
      // each segment ends in a full drain, often with a transfer cut mid-bit
      drain();
      pick = $urandom_range(9);
      if (pick == 0) t = '0;
      else if (pick < 8) t = TICKS_W'($urandom_range(3, 1));
      else t = TICKS_W'($urandom_range(9, 4));
      set_mode(1'($urandom_range(1)), 1'($urandom_range(1)), t);
      n       = $urandom_range(180, 60);
      // mostly busy request traffic, sometimes sparse noise
      req_pct = ($urandom_range(4) == 0) ? 5 : 35;
      repeat (n)
        push_word($urandom_range(99) < req_pct, 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      sent += n;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset mode, idle ticks, full frame with all-ones data
    repeat (3) push_word(1'b0, 8'hFF, 1'b1, 1'b1, 1'b1);
    queue_transfer(8'hFF, 1'b1, 1'b1, 1'b1);
    // cs held low across two bytes, then a byte with no chip select at all
    queue_transfer(8'h00, 1'b1, 1'b0, 1'b0);
    queue_transfer(8'hA5, 1'b0, 1'b1, 1'b1);
    queue_transfer(8'h5A, 1'b0, 1'b0, 1'b0);
    drain();
    // zero tick count behaves as one; idle sclk moves to the new polarity
    set_mode(1'b1, 1'b1, 16'd0);
    repeat (2) push_word(1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_transfer(8'h81, 1'b1, 1'b1, 1'b1);
    drain();
    set_mode(1'b0, 1'b1, 16'd2);
    queue_transfer(8'h7E, 1'b1, 1'b1, 1'b0);
    drain();
    set_mode(1'b1, 1'b0, 16'd3);
    queue_transfer(8'hC3, 1'b1, 1'b1, 1'b1);
    drain();
    // longest delay unit, then cut it short mid-phase with a live register write
    set_mode(1'b0, 1'b0, 16'hFFFF);
    push_word(1'b1, 8'h3C, 1'b1, 1'b1, 1'b1);
    repeat (30) push_word(1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
    drain();
    set_mode(1'b0, 1'b0, 16'd1);
    repeat (40) push_word(1'b0, 8'h00, 1'b0, 1'b0, 1'b1);

    // random traffic under three idling patterns
    run_phase(26, 85, RANDOM_WORDS_PER_PHASE);
    run_phase(85, 26, RANDOM_WORDS_PER_PHASE);
    run_phase(0, 0, RANDOM_WORDS_PER_PHASE);
    drain();

    $display("run covered %0d words checked of %0d sent, %0d transfers, %0d bytes received",
             words_checked, words_queued, transfers_seen, bytes_received);
    $display("clock modes used mask %b, %0d register writes", modes_used, reg_writes);
    if (mismatches == 0 && expected_pins.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/spim_pkg.sv
src/spim_queue.sv
src/spim_seq.sv
src/spi_master_four_mode_shifter_core.sv
sim/spi_master_four_mode_shifter_core_test.sv
